// ===== src/mosaic_capture_slide_controller_core_macros.svh =====
// Assertion helpers used by the checker in msc_checker.sv.
`ifndef MOSAIC_CAPTURE_SLIDE_CONTROLLER_CORE_MACROS_SVH
`define MOSAIC_CAPTURE_SLIDE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define MSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msc check failed");

// next-cycle implication
`define MSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msc check failed");

`endif

// ===== src/msc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

   localparam int MAX_TILES  = 1024;
   localparam int TILE_W     = 10;
   localparam int TCNT_W     = 11;
   localparam int BOX_W      = 12;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int MUL_W      = 22;
   localparam int PROD_W     = 2 * MUL_W;

   typedef enum logic [1:0] {
      REG_TILE_COUNT = 2'd0,
      REG_BOX_WIDTH  = 2'd1,
      REG_BOX_HEIGHT = 2'd2
   } reg_idx_type;

   typedef enum logic [1:0] {
      TAKE_NONE    = 2'd0,
      TAKE_CAPTURE = 2'd1,
      TAKE_REFRESH = 2'd2
   } take_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
      ST_M8, ST_M9, ST_M10, ST_M11, ST_M12, ST_M13, ST_M14, ST_FIN
   } state_type;

   typedef struct packed {
      logic [TCNT_W-1:0] tile_n;
      logic [BOX_W-1:0]  box_width;
      logic [BOX_W-1:0]  box_height;
      logic              tiles_changed;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/msc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface msc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] delay_target;
   logic [9:0] capture_level;
   logic [9:0] slide_level;

   modport source (output valid, delay_target, capture_level, slide_level, input ready);
   modport sink   (input valid, delay_target, capture_level, slide_level, output ready);
endinterface

`default_nettype wire

// ===== src/msc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface msc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         take_kind;
   logic [9:0]         tile_a;
   logic [9:0]         tile_b;
   logic signed [10:0] offset_x;
   logic signed [10:0] offset_y;
   logic [10:0]        amp_half_x;
   logic [10:0]        amp_half_y;
   logic [3:0]         luma_boost;

   modport source (output valid, take_kind, tile_a, tile_b, offset_x, offset_y,
                   amp_half_x, amp_half_y, luma_boost, input ready);
   modport sink   (input valid, take_kind, tile_a, tile_b, offset_x, offset_y,
                   amp_half_x, amp_half_y, luma_boost, output ready);
endinterface

`default_nettype wire

// ===== src/mosaic_capture_slide_controller_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port      Dir  Handshake              Carries
// req_if    in   valid/ready            delay_target, capture_level, slide_level
// rsp_if    out  valid/ready            take_kind, tile_a/b, offset_x/y, amp_half_x/y, luma_boost
// csr_*     in   APB write, pready = 1  tile_count @0x0, box_width @0x4, box_height @0x8
//
// Items are taken one at a time: accept, 14 steps that issue 13 products on the shared
// 22x22 multiplier (registered), and a final state that loads the result register.
// The next item is taken while the result waits in that register.
// If the previous result is still held, the item parks in its last step.
// Synchronous reset clears envelopes, phase, cursor and countdown; registers go to 4/320/240.

module mosaic_capture_slide_controller_core
   import msc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   msc_req_if.sink               req_if,
   msc_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // reciprocals: floor(v / d) == (v * R) >> S over the operand ranges used
   localparam logic signed [MUL_W-1:0] RECIP_1000 = MUL_W'(268436);
   localparam logic signed [MUL_W-1:0] RECIP_255  = MUL_W'(65794);
   localparam logic signed [MUL_W-1:0] RECIP_540  = MUL_W'(1988411);
   localparam logic signed [MUL_W-1:0] K_DE_RISE  = MUL_W'(96);
   localparam logic signed [MUL_W-1:0] K_DE_FALL  = MUL_W'(44);
   localparam logic signed [MUL_W-1:0] K_CE_RISE  = MUL_W'(92);
   localparam logic signed [MUL_W-1:0] K_CE_FALL  = MUL_W'(46);
   localparam logic signed [MUL_W-1:0] K_SE_RISE  = MUL_W'(86);
   localparam logic signed [MUL_W-1:0] K_SE_FALL  = MUL_W'(42);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic [15:0]       de_ff, de_in;
   logic [7:0]        ce_ff, ce_in;
   logic [7:0]        se_ff, se_in;
   logic [9:0]        phase_ff, phase_in;
   logic [TILE_W-1:0] cursor_ff, cursor_in;
   logic              started_ff, started_in;
   logic [7:0]        fc_ff, fc_in;

   logic [7:0]         dt_ff, dt_in;
   logic [17:0]        vc_ff, vc_in;
   logic [17:0]        vs_ff, vs_in;
   logic [7:0]         eff_ff, eff_in;
   logic [10:0]        ax_ff, ax_in;
   logic [10:0]        ay_ff, ay_in;
   logic signed [10:0] gx_ff, gx_in;
   logic signed [10:0] gy_ff, gy_in;
   take_type           kind_ff, kind_in;
   logic [TILE_W-1:0]  ta_ff, ta_in;
   logic [TILE_W-1:0]  tb_ff, tb_in;

   logic               out_valid_ff, out_valid_in;
   take_type           o_kind_ff, o_kind_in;
   logic [TILE_W-1:0]  o_ta_ff, o_ta_in;
   logic [TILE_W-1:0]  o_tb_ff, o_tb_in;
   logic signed [10:0] o_gx_ff, o_gx_in;
   logic signed [10:0] o_gy_ff, o_gy_in;
   logic [10:0]        o_sx_ff, o_sx_in;
   logic [10:0]        o_sy_ff, o_sy_in;
   logic [3:0]         o_boost_ff, o_boost_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;

   logic [15:0]       env_d;
   logic signed [17:0] d_del;
   logic signed [8:0]  d_cap, d_sld;
   logic [16:0]       dl_round;
   logic [7:0]        delay;
   logic [7:0]        delay_m1;
   logic [10:0]       q_ab;
   logic [10:0]       half_w, half_h;
   logic signed [9:0] wx, wy;
   logic [9:0]        phase_q;
   logic [11:0]       boost_full;
   logic [7:0]        fc_min;
   logic              take;
   logic [TCNT_W-1:0] cur_ext, nxt1, nxt2, nxt2_wrap, n_m1;

   // asymmetric envelope step: floor((p +/- 128) / 256)
   function automatic logic [15:0] env_delta(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      r = p[PROD_W-1] ? p - PROD_W'(128) : p + PROD_W'(128);
      r = r >>> 8;
      return r[15:0];
   endfunction

   // saturated drive scaled for the /1000 step: min(x,1000)*255 + 500
   function automatic logic [17:0] drive_num(input logic [9:0] x);
      logic [17:0] xe;
      xe = (x > 10'd1000) ? 18'd1000 : 18'(x);
      return (xe << 8) - xe + 18'd500;
   endfunction

   function automatic logic signed [9:0] tri_wave(input logic [9:0] ph);
      logic [8:0] t;
      t = ph[9] ? ~ph[8:0] : ph[8:0];
      return $signed({1'b0, t}) - 10'sd256;
   endfunction

   function automatic logic signed [10:0] sat_off(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      r = p >>> 8;
      if (r > PROD_W'(1023)) begin
         return 11'sd1023;
      end else if (r < -PROD_W'(1024)) begin
         return -11'sd1024;
      end
      return r[10:0];
   endfunction

   msc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   msc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   assign env_d    = env_delta(prod);
   assign d_del    = $signed({2'b00, dt_ff, 8'h00}) - $signed({2'b00, de_ff});
   assign d_cap    = $signed({1'b0, prod[35:28]}) - $signed({1'b0, ce_ff});
   assign d_sld    = $signed({1'b0, prod[35:28]}) - $signed({1'b0, se_ff});
   assign dl_round = {1'b0, de_ff} + 17'd128;
   assign delay    = (dl_round[16:8] == 9'd0)   ? 8'd1 :
                     (dl_round[16:8] > 9'd250)  ? 8'd250 : dl_round[15:8];
   assign delay_m1 = delay - 8'd1;
   assign q_ab     = prod[40:30];
   assign half_w   = cfg.box_width[BOX_W-1:1];
   assign half_h   = cfg.box_height[BOX_W-1:1];
   assign phase_q  = phase_ff + 10'd256;
   assign wx       = tri_wave(phase_ff);
   assign wy       = tri_wave(phase_q);
   assign boost_full = {1'b0, se_ff, 3'b000} + {3'b000, se_ff, 1'b0};

   // frame countdown and tile cursor
   assign fc_min    = (fc_ff > eff_ff) ? eff_ff : fc_ff;
   assign take      = fc_min <= 8'd1;
   assign cur_ext   = {1'b0, cursor_ff};
   assign nxt1      = cur_ext + TCNT_W'(1);
   assign nxt2      = cur_ext + TCNT_W'(2);
   assign nxt2_wrap = nxt2 - cfg.tile_n;
   assign n_m1      = cfg.tile_n - TCNT_W'(1);

   assign req_if.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      de_in      = de_ff;
      ce_in      = ce_ff;
      se_in      = se_ff;
      phase_in   = phase_ff;
      cursor_in  = cursor_ff;
      started_in = started_ff;
      fc_in      = fc_ff;
      dt_in      = dt_ff;
      vc_in      = vc_ff;
      vs_in      = vs_ff;
      eff_in     = eff_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      gx_in      = gx_ff;
      gy_in      = gy_ff;
      kind_in    = kind_ff;
      ta_in      = ta_ff;
      tb_in      = tb_ff;
      mul_a      = '0;
      mul_b      = '0;

      out_valid_in = out_valid_ff & ~rsp_if.ready;
      o_kind_in    = o_kind_ff;
      o_ta_in      = o_ta_ff;
      o_tb_in      = o_tb_ff;
      o_gx_in      = o_gx_ff;
      o_gy_in      = o_gy_ff;
      o_sx_in      = o_sx_ff;
      o_sy_in      = o_sy_ff;
      o_boost_in   = o_boost_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               dt_in = req_if.delay_target;
               vc_in = drive_num(req_if.capture_level);
               vs_in = drive_num(req_if.slide_level);
               // empty envelope starts at the target
               if (de_ff == 16'd0) begin
                  de_in = {req_if.delay_target, 8'h00};
               end
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            mul_a    = MUL_W'(d_del);
            mul_b    = d_del[17] ? K_DE_FALL : K_DE_RISE;
            state_in = ST_M2;
         end
         ST_M2: begin
            de_in    = de_ff + env_d;
            mul_a    = MUL_W'(vc_ff);
            mul_b    = RECIP_1000;
            state_in = ST_M3;
         end
         ST_M3: begin
            mul_a    = MUL_W'(d_cap);
            mul_b    = d_cap[8] ? K_CE_FALL : K_CE_RISE;
            state_in = ST_M4;
         end
         ST_M4: begin
            ce_in    = ce_ff + env_d[7:0];
            mul_a    = MUL_W'(vs_ff);
            mul_b    = RECIP_1000;
            state_in = ST_M5;
         end
         ST_M5: begin
            mul_a    = MUL_W'(d_sld);
            mul_b    = d_sld[8] ? K_SE_FALL : K_SE_RISE;
            state_in = ST_M6;
         end
         ST_M6: begin
            se_in    = se_ff + env_d[7:0];
            mul_a    = MUL_W'(delay_m1);
            mul_b    = MUL_W'(ce_ff);
            state_in = ST_M7;
         end
         ST_M7: begin
            mul_a    = MUL_W'(prod[15:0]);
            mul_b    = RECIP_255;
            state_in = ST_M8;
         end
         ST_M8: begin
            eff_in   = delay - prod[31:24];
            mul_a    = MUL_W'(cfg.box_width);
            mul_b    = MUL_W'(se_ff);
            state_in = ST_M9;
         end
         ST_M9: begin
            if (take) begin
               kind_in    = TAKE_CAPTURE;
               ta_in      = cursor_ff;
               tb_in      = (nxt1 == cfg.tile_n) ? '0 : nxt1[TILE_W-1:0];
               cursor_in  = (nxt2 >= cfg.tile_n) ? nxt2_wrap[TILE_W-1:0] : nxt2[TILE_W-1:0];
               started_in = 1'b1;
               fc_in      = eff_ff;
            end else begin
               fc_in = fc_min - 8'd1;
               if (started_ff) begin
                  kind_in = TAKE_REFRESH;
                  ta_in   = (cursor_ff == '0) ? n_m1[TILE_W-1:0] : cursor_ff - TILE_W'(1);
                  tb_in   = cursor_ff;
               end else begin
                  kind_in = TAKE_NONE;
                  ta_in   = '0;
                  tb_in   = '0;
               end
            end
            phase_in = phase_ff + 10'd2 + 10'(se_ff[7:4]);
            mul_a    = MUL_W'(prod[19:0]);
            mul_b    = RECIP_540;
            state_in = ST_M10;
         end
         ST_M10: begin
            ax_in    = (q_ab > half_w) ? half_w : q_ab;
            mul_a    = MUL_W'(cfg.box_height);
            mul_b    = MUL_W'(se_ff);
            state_in = ST_M11;
         end
         ST_M11: begin
            mul_a    = MUL_W'(prod[19:0]);
            mul_b    = RECIP_540;
            state_in = ST_M12;
         end
         ST_M12: begin
            ay_in    = (q_ab > half_h) ? half_h : q_ab;
            mul_a    = MUL_W'(ax_ff);
            mul_b    = MUL_W'(wx);
            state_in = ST_M13;
         end
         ST_M13: begin
            gx_in    = sat_off(prod);
            mul_a    = MUL_W'(ay_ff);
            mul_b    = MUL_W'(wy);
            state_in = ST_M14;
         end
         ST_M14: begin
            gy_in    = sat_off(prod);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_if.ready) begin
               out_valid_in = 1'b1;
               o_kind_in    = kind_ff;
               o_ta_in      = ta_ff;
               o_tb_in      = tb_ff;
               o_gx_in      = gx_ff;
               o_gy_in      = gy_ff;
               o_sx_in      = {1'b0, ax_ff[10:1]};
               o_sy_in      = {1'b0, ay_ff[10:1]};
               o_boost_in   = boost_full[11:8];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a new effective tile count restarts the capture sequence
      if (cfg.tiles_changed) begin
         cursor_in  = '0;
         started_in = 1'b0;
         fc_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         de_ff        <= '0;
         ce_ff        <= '0;
         se_ff        <= '0;
         phase_ff     <= '0;
         cursor_ff    <= '0;
         started_ff   <= 1'b0;
         fc_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         de_ff        <= de_in;
         ce_ff        <= ce_in;
         se_ff        <= se_in;
         phase_ff     <= phase_in;
         cursor_ff    <= cursor_in;
         started_ff   <= started_in;
         fc_ff        <= fc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff      <= dt_in;
      vc_ff      <= vc_in;
      vs_ff      <= vs_in;
      eff_ff     <= eff_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      kind_ff    <= kind_in;
      ta_ff      <= ta_in;
      tb_ff      <= tb_in;
      o_kind_ff  <= o_kind_in;
      o_ta_ff    <= o_ta_in;
      o_tb_ff    <= o_tb_in;
      o_gx_ff    <= o_gx_in;
      o_gy_ff    <= o_gy_in;
      o_sx_ff    <= o_sx_in;
      o_sy_ff    <= o_sy_in;
      o_boost_ff <= o_boost_in;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.take_kind  = o_kind_ff;
   assign rsp_if.tile_a     = o_ta_ff;
   assign rsp_if.tile_b     = o_tb_ff;
   assign rsp_if.offset_x   = o_gx_ff;
   assign rsp_if.offset_y   = o_gy_ff;
   assign rsp_if.amp_half_x = o_sx_ff;
   assign rsp_if.amp_half_y = o_sy_ff;
   assign rsp_if.luma_boost = o_boost_ff;

endmodule

`default_nettype wire

// ===== src/msc_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msc_csr
   import msc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [TCNT_W-1:0] tile_count_ff, tile_count_in;
   logic [BOX_W-1:0]  box_width_ff, box_width_in;
   logic [BOX_W-1:0]  box_height_ff, box_height_in;
   logic              wr;
   logic              tiles_changed;
   reg_idx_type       idx;

   // count clamped to the usable range
   function automatic logic [TCNT_W-1:0] eff_tiles(input logic [TCNT_W-1:0] r);
      if (r < TCNT_W'(4)) begin
         return TCNT_W'(4);
      end else if (r > TCNT_W'(MAX_TILES)) begin
         return TCNT_W'(MAX_TILES);
      end
      return r;
   endfunction

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      tile_count_in = tile_count_ff;
      box_width_in  = box_width_ff;
      box_height_in = box_height_ff;
      tiles_changed = 1'b0;
      if (wr) begin
         case (idx)
            REG_TILE_COUNT: begin
               tile_count_in = pwdata[TCNT_W-1:0];
               tiles_changed = eff_tiles(pwdata[TCNT_W-1:0]) != eff_tiles(tile_count_ff);
            end
            REG_BOX_WIDTH:  box_width_in  = pwdata[BOX_W-1:0];
            REG_BOX_HEIGHT: box_height_in = pwdata[BOX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_TILE_COUNT: prdata = CSR_DATA_W'(tile_count_ff);
         REG_BOX_WIDTH:  prdata = CSR_DATA_W'(box_width_ff);
         REG_BOX_HEIGHT: prdata = CSR_DATA_W'(box_height_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.tile_n        = eff_tiles(tile_count_ff);
   assign cfg.box_width     = box_width_ff;
   assign cfg.box_height    = box_height_ff;
   assign cfg.tiles_changed = tiles_changed;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_count_ff <= TCNT_W'(4);
         box_width_ff  <= BOX_W'(320);
         box_height_ff <= BOX_W'(240);
      end else begin
         tile_count_ff <= tile_count_in;
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/msc_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msc_mul
   import msc_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  mul_a,
   input  logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0] prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== src/msc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "mosaic_capture_slide_controller_core_macros.svh"

module msc_checker
   import msc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [9:0] rsp_ta,
   input logic [9:0] rsp_tb
);

   // a stalled result keeps its take kind and its first tile
   `MSC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ta) && $stable(rsp_kind))

   // one item at a time, and no result right after an accept
   `MSC_ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready, !req_ready && !$rose(rsp_valid))

   // a result only comes out of a busy block
   `MSC_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // no take means no tiles
   `MSC_ASSERT_IMP(a_no_tiles, clock, reset, rsp_valid && rsp_kind == TAKE_NONE, rsp_ta == '0 && rsp_tb == '0)

endmodule

bind mosaic_capture_slide_controller_core msc_checker u_msc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_kind  (rsp_if.take_kind),
   .rsp_ta    (rsp_if.tile_a),
   .rsp_tb    (rsp_if.tile_b)
);

`default_nettype wire

// ===== test/msc_frame_checker.sv =====
`timescale 1ns / 1ps

module msc_frame_checker
   import msc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   msc_req_if                    req_if,
   msc_rsp_if                    rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    pending,
   output int                    frames_checked,
   output int                    captures,
   output int                    refreshes
);

   typedef struct {
      take_type           take;
      logic [9:0]         tile_a;
      logic [9:0]         tile_b;
      logic signed [10:0] off_x;
      logic signed [10:0] off_y;
      logic [10:0]        stag_x;
      logic [10:0]        stag_y;
      logic [3:0]         boost;
   } frame_result_t;

   frame_result_t expected_frames[$];

   // register copies
   logic [TCNT_W-1:0] tiles_reg;
   logic [BOX_W-1:0]  width_reg;
   logic [BOX_W-1:0]  height_reg;

   // controller state
   logic [15:0] delay_env;
   logic [7:0]  capture_env;
   logic [7:0]  slide_env;
   logic [9:0]  phase;
   logic [9:0]  cursor;
   logic        started;
   logic [7:0]  countdown;

   function automatic int clampi(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // asymmetric attack/release step in Q8, floor rounding on the shift
   function automatic int glide(input int cur, input int target, input int rise, input int fall);
      int d;
      d = target - cur;
      if (d >= 0)
         return cur + ((d * rise + 128) >>> 8);
      return cur + ((d * fall - 128) >>> 8);
   endfunction

   function automatic int drive_level(input logic [9:0] v);
      int x;
      x = (v > 10'd1000) ? 1000 : int'(v);
      return (x * 255 + 500) / 1000;
   endfunction

   function automatic int triangle(input int ph);
      int p;
      p = ph & 1023;
      return ((p < 512) ? p : 1023 - p) - 256;
   endfunction

   function automatic int tiles_in_use(input logic [TCNT_W-1:0] r);
      if (r < 4)
         return 4;
      if (r > MAX_TILES)
         return MAX_TILES;
      return int'(r);
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] data);
      case (reg_idx_type'(addr[CSR_ADDR_W-1:2]))
         REG_TILE_COUNT: begin
            if (tiles_in_use(data[TCNT_W-1:0]) != tiles_in_use(tiles_reg)) begin
               cursor    = '0;
               started   = 1'b0;
               countdown = '0;
            end
            tiles_reg = data[TCNT_W-1:0];
         end
         REG_BOX_WIDTH:  width_reg = data[BOX_W-1:0];
         REG_BOX_HEIGHT: height_reg = data[BOX_W-1:0];
         default: ;
      endcase
   endtask

   function automatic frame_result_t advance_frame(input logic [7:0] dt,
                                                   input logic [9:0] cd,
                                                   input logic [9:0] sd);
      int dtarget, n, denv, cenv, senv, delay, eff, fc, cur, sq;
      int ax, ay, wx, wy, gx, gy;
      logic take_now;
      frame_result_t r;
      dtarget = int'(dt) * 256;
      n = tiles_in_use(tiles_reg);
      denv = int'(delay_env);
      if (denv == 0)
         denv = dtarget;
      denv = glide(denv, dtarget, 96, 44);
      cenv = glide(int'(capture_env), drive_level(cd), 92, 46);
      senv = glide(int'(slide_env), drive_level(sd), 86, 42);
      delay_env   = denv[15:0];
      capture_env = cenv[7:0];
      slide_env   = senv[7:0];

      delay = clampi((denv + 128) / 256, 1, 250);
      eff = clampi(delay - ((delay - 1) * cenv) / 255, 1, delay);

      fc = int'(countdown);
      if (fc > eff)
         fc = eff;
      if (fc <= 0) begin
         take_now = 1'b1;
      end else begin
         fc--;
         take_now = (fc <= 0);
      end

      r.take   = TAKE_NONE;
      r.tile_a = '0;
      r.tile_b = '0;
      cur = int'(cursor);
      if (take_now) begin
         r.take   = TAKE_CAPTURE;
         r.tile_a = 10'(cur % n);
         r.tile_b = 10'((cur + 1) % n);
         cursor   = 10'((cur + 2) % n);
         started  = 1'b1;
         fc = eff;
      end else if (started) begin
         r.take   = TAKE_REFRESH;
         r.tile_a = 10'((cur % n + n - 1) % n);
         r.tile_b = 10'(cur % n);
      end
      countdown = 8'(fc);

      sq = senv;
      phase = 10'(int'(phase) + 2 + (sq >> 4));
      wx = triangle(int'(phase));
      wy = triangle(int'(phase) + 256);

      ax = (int'(width_reg) * sq) / 540;
      ay = (int'(height_reg) * sq) / 540;
      if (ax > (int'(width_reg) >> 1))
         ax = int'(width_reg) >> 1;
      if (ay > (int'(height_reg) >> 1))
         ay = int'(height_reg) >> 1;
      gx = clampi((ax * wx) >>> 8, -1024, 1023);
      gy = clampi((ay * wy) >>> 8, -1024, 1023);

      r.off_x  = 11'(gx);
      r.off_y  = 11'(gy);
      r.stag_x = 11'(ax >> 1);
      r.stag_y = 11'(ay >> 1);
      r.boost  = 4'((sq * 10) >> 8);
      return r;
   endfunction

   always @(posedge clock) begin
      frame_result_t want;
      frame_result_t got;
      if (reset) begin
         tiles_reg   = 11'd4;
         width_reg   = 12'd320;
         height_reg  = 12'd240;
         delay_env   = '0;
         capture_env = '0;
         slide_env   = '0;
         phase       = '0;
         cursor      = '0;
         started     = 1'b0;
         countdown   = '0;
         expected_frames.delete();
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_register(csr_paddr, csr_pwdata);

         // compare before queuing, so an item taken this edge cannot match
         if (rsp_if.valid && rsp_if.ready) begin
            got.take   = take_type'(rsp_if.take_kind);
            got.tile_a = rsp_if.tile_a;
            got.tile_b = rsp_if.tile_b;
            got.off_x  = rsp_if.offset_x;
            got.off_y  = rsp_if.offset_y;
            got.stag_x = rsp_if.amp_half_x;
            got.stag_y = rsp_if.amp_half_y;
            got.boost  = rsp_if.luma_boost;
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("result with no item outstanding, take_kind %0d",
                                         got.take));
            end else begin
               want = expected_frames.pop_front();
               if (got.take !== want.take)
                  report_mismatch($sformatf("frame %0d take_kind %0d, want %0d",
                                            frames_checked, got.take, want.take));
               if (got.tile_a !== want.tile_a)
                  report_mismatch($sformatf("frame %0d tile_a %0d, want %0d",
                                            frames_checked, got.tile_a, want.tile_a));
               if (got.tile_b !== want.tile_b)
                  report_mismatch($sformatf("frame %0d tile_b %0d, want %0d",
                                            frames_checked, got.tile_b, want.tile_b));
               if (got.off_x !== want.off_x)
                  report_mismatch($sformatf("frame %0d offset_x %0d, want %0d",
                                            frames_checked, got.off_x, want.off_x));
               if (got.off_y !== want.off_y)
                  report_mismatch($sformatf("frame %0d offset_y %0d, want %0d",
                                            frames_checked, got.off_y, want.off_y));
               if (got.stag_x !== want.stag_x)
                  report_mismatch($sformatf("frame %0d amp_half_x %0d, want %0d",
                                            frames_checked, got.stag_x, want.stag_x));
               if (got.stag_y !== want.stag_y)
                  report_mismatch($sformatf("frame %0d amp_half_y %0d, want %0d",
                                            frames_checked, got.stag_y, want.stag_y));
               if (got.boost !== want.boost)
                  report_mismatch($sformatf("frame %0d luma_boost %0d, want %0d",
                                            frames_checked, got.boost, want.boost));
               if (want.take == TAKE_CAPTURE)
                  captures++;
               else if (want.take == TAKE_REFRESH)
                  refreshes++;
            end
            frames_checked++;
         end

         if (req_if.valid && req_if.ready)
            expected_frames.push_back(advance_frame(req_if.delay_target,
                                                    req_if.capture_level,
                                                    req_if.slide_level));
         pending <= expected_frames.size();
      end
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import msc_pkg::*;

   localparam int HOLDOFF_CYCLES = 300;
   localparam int PHASES         = 8;
   localparam int PHASE_FRAMES   = 216;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   msc_req_if req_if();
   msc_rsp_if rsp_if();

   int   fail_count;
   int   pending;
   int   frames_checked;
   int   captures;
   int   refreshes;
   int   frames_sent;
   int   reg_writes;
   logic no_idle = 1'b0;
   int   holdoff_asked;
   int   holdoff_done;

   mosaic_capture_slide_controller_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   msc_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .fail_count     (fail_count),
      .pending        (pending),
      .frames_checked (frames_checked),
      .captures       (captures),
      .refreshes      (refreshes)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("mosaic_capture_slide_controller_core regression: fail");
      $finish;
   end

   // result side: random stalls, plus a long counted hold-off on request
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_done != holdoff_asked) begin
            rsp_if.ready <= 1'b0;
            stall = 0;
            while (stall < HOLDOFF_CYCLES) begin
               @(posedge clock);
               stall++;
            end
            holdoff_done++;
         end
         rsp_if.ready <= no_idle || ($urandom_range(99) >= 38);
      end
   end

   task automatic offer_frame(input logic [7:0] dt, input logic [9:0] cd, input logic [9:0] sd);
      if (!no_idle)
         while ($urandom_range(99) < 38) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      req_if.valid         <= 1'b1;
      req_if.delay_target  <= dt;
      req_if.capture_level <= cd;
      req_if.slide_level   <= sd;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      frames_sent++;
   endtask

   // hold the input until every outstanding frame has come back
   task automatic settle_frames();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input reg_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   function automatic logic [11:0] pick_box();
      case ($urandom_range(9))
         0: return 12'd0;
         1: return 12'd4095;
         2: return 12'd2048;
         3: return 12'd1;
         default: return 12'($urandom_range(1, 2048));
      endcase
   endfunction

   initial begin
      logic [7:0]  base_dt;
      logic [9:0]  base_cd;
      logic [9:0]  base_sd;
      logic [7:0]  dt;
      logic [9:0]  cd;
      logic [9:0]  sd;
      logic [10:0] tiles;
      int          pick;

      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.delay_target  <= '0;
      req_if.capture_level <= '0;
      req_if.slide_level   <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty delay envelope loads the target; first frame always captures
      offer_frame(8'd250, 10'd0, 10'd0);
      repeat (3) offer_frame(8'd250, 10'd0, 10'd0);
      // drives above range, delay above and below range
      offer_frame(8'd255, 10'd1023, 10'd1023);
      offer_frame(8'd0, 10'd1000, 10'd1000);
      offer_frame(8'd1, 10'd0, 10'd1023);
      offer_frame(8'd1, 10'd1023, 10'd0);
      offer_frame(8'd128, 10'd500, 10'd512);
      settle_frames();

      // tile count below range maps to the same count: cursor kept
      write_reg(REG_TILE_COUNT, 32'd0);
      write_reg(REG_BOX_WIDTH, 32'd4095);
      write_reg(REG_BOX_HEIGHT, 32'd4095);
      repeat (4) offer_frame(8'd2, 10'd1000, 10'd1000);
      settle_frames();

      write_reg(REG_TILE_COUNT, 32'd2047);
      write_reg(REG_BOX_WIDTH, 32'd0);
      write_reg(REG_BOX_HEIGHT, 32'd1);
      repeat (4) offer_frame(8'd1, 10'd1023, 10'd1023);
      settle_frames();

      write_reg(REG_TILE_COUNT, 32'd3);
      write_reg(REG_BOX_WIDTH, 32'd2048);
      write_reg(REG_BOX_HEIGHT, 32'd2048);
      repeat (3) offer_frame(8'd1, 10'd0, 10'd1000);
      settle_frames();

      write_reg(REG_TILE_COUNT, 32'd1025);
      offer_frame(8'd3, 10'd200, 10'd800);
      settle_frames();
      write_reg(REG_TILE_COUNT, 32'd1024);
      offer_frame(8'd3, 10'd200, 10'd800);

      for (int p = 0; p < PHASES; p++) begin
         settle_frames();
         if (p == 0 || $urandom_range(99) < 60) begin
            case ($urandom_range(9))
               0: tiles = 11'd0;
               1: tiles = 11'd2047;
               2: tiles = 11'($urandom_range(1023, 1025));
               3, 4: tiles = 11'($urandom_range(2047));
               default: tiles = 11'($urandom_range(4, 20));
            endcase
            write_reg(REG_TILE_COUNT, 32'(tiles));
         end
         if (p == 0 || $urandom_range(99) < 60)
            write_reg(REG_BOX_WIDTH, 32'(pick_box()));
         if (p == 0 || $urandom_range(99) < 60)
            write_reg(REG_BOX_HEIGHT, 32'(pick_box()));
         no_idle <= (p == 2);

         for (int k = 0; k < PHASE_FRAMES; k++) begin
            // hold a scene for a while so the envelopes settle
            if (k % 40 == 0) begin
               pick = $urandom_range(99);
               if (pick < 50)
                  base_dt = 8'($urandom_range(1, 6));
               else if (pick < 85)
                  base_dt = 8'($urandom_range(1, 250));
               else
                  base_dt = 8'($urandom_range(255));
               base_cd = 10'($urandom_range(1023));
               base_sd = 10'($urandom_range(1023));
            end
            if ((p == 4 || p == 7) && k == 30)
               holdoff_asked <= holdoff_asked + 1;
            if (p == 5 && k == 100)
               settle_frames();
            dt = ($urandom_range(99) < 75) ? base_dt : 8'($urandom_range(255));
            cd = ($urandom_range(99) < 70) ? base_cd : 10'($urandom_range(1023));
            sd = ($urandom_range(99) < 70) ? base_sd : 10'($urandom_range(1023));
            offer_frame(dt, cd, sd);
         end
      end

      settle_frames();
      repeat (32) @(posedge clock);

      $display("%0d frames sent, %0d checked (%0d captures, %0d refreshes), %0d register writes,",
               frames_sent, frames_checked, captures, refreshes, reg_writes);
      $display("with tile counts and box sizes at their limits and long output hold-offs");
      if (fail_count == 0)
         $display("mosaic_capture_slide_controller_core regression: pass");
      else
         $display("mosaic_capture_slide_controller_core regression: fail");
      $finish;
   end

endmodule
